// ===== rtl/gregorian_date_adder_macros.svh =====
// Assertion macros shared by the date adder modules.
`ifndef GREGORIAN_DATE_ADDER_MACROS_SVH
`define GREGORIAN_DATE_ADDER_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define GDA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Same-cycle implication.
`define GDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gda_pkg.sv =====
// Types, constants and helpers of the Gregorian date adder.
package gda_pkg;

  // Field widths of the words on the channels
  localparam int CMD_W    = 2;
  localparam int YEAR_W   = 16;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int AMOUNT_W = 16;

  // Arithmetic widths
  localparam int YEAR_BITS   = 16;
  localparam int AMOUNT_BITS = 16;
  localparam int SUM_W = ((YEAR_BITS > AMOUNT_BITS) ? YEAR_BITS : AMOUNT_BITS) + 1;
  localparam int ACC_W = AMOUNT_BITS + 1;

  localparam longint unsigned YEAR_MAX  = (64'd1 << YEAR_BITS) - 64'd1;
  localparam longint unsigned DAYS_400  = 64'd146097;
  localparam longint unsigned YEARS_400 = 64'd400;

  // year / 100 by reciprocal multiply
  localparam int SHIFT_100 = YEAR_BITS + 7;
  localparam int M100_W    = YEAR_BITS + 1;
  localparam int P100_W    = YEAR_BITS + M100_W;
  localparam int Q100_W    = P100_W - SHIFT_100;
  localparam longint unsigned RECIP_100 = ((64'd1 << SHIFT_100) / 100) + 64'd1;

  // month total / 12 by reciprocal multiply
  localparam int SHIFT_12 = ACC_W + 4;
  localparam int M12_W    = ACC_W + 1;
  localparam int P12_W    = ACC_W + M12_W;
  localparam int Q12_W    = P12_W - SHIFT_12;
  localparam longint unsigned RECIP_12 = ((64'd1 << SHIFT_12) / 12) + 64'd1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DAYS   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MONTHS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_YEARS  = 2'd3;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_ONE = 5'd1;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_CYC,
    OP_LQ,
    OP_LF,
    OP_WALK,
    OP_MQ,
    OP_MR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic cyc_go;     // a whole 400-year step fits
    logic walk_done;  // remaining days fit into the current month
    logic walk_wrap;  // current month is December
  } dp_stat_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/gda_if.sv =====
// Valid/ready channel interfaces for the command and result words.
interface gda_in_if;
  logic                          valid;
  logic                          ready;
  logic [gda_pkg::CMD_W-1:0]     cmd;
  logic [gda_pkg::YEAR_W-1:0]    load_year;
  logic [gda_pkg::MONTH_W-1:0]   load_month;
  logic [gda_pkg::DAY_W-1:0]     load_day;
  logic [gda_pkg::AMOUNT_W-1:0]  amount;

  modport source (output valid, cmd, load_year, load_month, load_day, amount,
                  input ready);
  modport sink (input valid, cmd, load_year, load_month, load_day, amount,
                output ready);
endinterface

interface gda_out_if;
  logic                          valid;
  logic                          ready;
  logic [gda_pkg::YEAR_W-1:0]    out_year;
  logic [gda_pkg::MONTH_W-1:0]   out_month;
  logic [gda_pkg::DAY_W-1:0]     out_day;
  logic                          year_overflow;

  modport source (output valid, out_year, out_month, out_day, year_overflow,
                  input ready);
  modport sink (input valid, out_year, out_month, out_day, year_overflow,
                output ready);
endinterface

// ===== rtl/gda_datapath.sv =====
// Date registers, day accumulator and divide-by-constant units.
`include "gregorian_date_adder_macros.svh"

module gda_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gda_pkg::dp_cmd_t                ctrl_i,
  output gda_pkg::dp_stat_t               stat_o,
  input  logic [gda_pkg::CMD_W-1:0]       cmd_i,
  input  logic [gda_pkg::YEAR_W-1:0]      load_year_i,
  input  logic [gda_pkg::MONTH_W-1:0]     load_month_i,
  input  logic [gda_pkg::DAY_W-1:0]       load_day_i,
  input  logic [gda_pkg::AMOUNT_W-1:0]    amount_i,
  output logic [gda_pkg::YEAR_W-1:0]      out_year_o,
  output logic [gda_pkg::MONTH_W-1:0]     out_month_o,
  output logic [gda_pkg::DAY_W-1:0]       out_day_o,
  output logic                            year_overflow_o
);

  localparam int YB = gda_pkg::YEAR_BITS;
  localparam int AW = gda_pkg::ACC_W;
  localparam int SW = gda_pkg::SUM_W;

  logic [YB-1:0]               year_q;
  logic [gda_pkg::MONTH_W-1:0] month_q;
  logic [gda_pkg::DAY_W-1:0]   day_q;
  logic                        ovf_q;
  logic [AW-1:0]               acc_q;
  logic [gda_pkg::Q100_W-1:0]  q100_q;
  logic                        leap_q;
  logic [gda_pkg::Q12_W-1:0]   q12_q;

  logic [gda_pkg::AMOUNT_BITS-1:0] amt;
  logic [gda_pkg::DAY_W-1:0]       len;
  logic [gda_pkg::P100_W-1:0]      prod100;
  logic [gda_pkg::P12_W-1:0]       prod12;
  logic [YB-1:0]                   qx100;
  logic [YB-1:0]                   hundreds;
  logic [AW-1:0]                   qx12;
  logic [AW-1:0]                   rem12;
  logic [SW-1:0]                   ysum_amt;
  logic [SW-1:0]                   ysum_q12;
  logic [gda_pkg::MONTH_W-1:0]     load_month;
  logic [gda_pkg::DAY_W-1:0]       load_day;
  logic                            leap;

  assign amt      = gda_pkg::AMOUNT_BITS'(amount_i);
  assign len      = gda_pkg::month_len(month_q, leap_q);
  assign prod100  = gda_pkg::P100_W'(year_q) * gda_pkg::P100_W'(gda_pkg::RECIP_100);
  assign prod12   = gda_pkg::P12_W'(acc_q) * gda_pkg::P12_W'(gda_pkg::RECIP_12);
  assign qx100    = YB'(q100_q);
  assign hundreds = (qx100 << 6) + (qx100 << 5) + (qx100 << 2);
  assign qx12     = AW'(q12_q);
  assign rem12    = acc_q - ((qx12 << 3) + (qx12 << 2));
  assign ysum_amt = SW'(year_q) + SW'(amt);
  assign ysum_q12 = SW'(year_q) + SW'(q12_q);

  // divisible by 4 and not by 100, or divisible by 400
  assign leap = ((year_q[1:0] == 2'b00) && (year_q != hundreds)) ||
                ((year_q == hundreds) && (q100_q[1:0] == 2'b00));

  always_comb begin
    if (load_month_i == '0) begin
      load_month = gda_pkg::MONTH_JAN;
    end else if (load_month_i > gda_pkg::MONTH_DEC) begin
      load_month = gda_pkg::MONTH_DEC;
    end else begin
      load_month = load_month_i;
    end
    load_day = (load_day_i == '0) ? gda_pkg::DAY_ONE : load_day_i;
  end

  assign stat_o.cyc_go    = (64'(acc_q) > gda_pkg::DAYS_400) &&
                            (64'(year_q) <= (gda_pkg::YEAR_MAX - gda_pkg::YEARS_400));
  assign stat_o.walk_done = (acc_q <= AW'(len));
  assign stat_o.walk_wrap = (month_q == gda_pkg::MONTH_DEC);

  // Stored date and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= '0;
      month_q <= gda_pkg::MONTH_JAN;
      day_q   <= gda_pkg::DAY_ONE;
      ovf_q   <= 1'b0;
    end else begin
      unique case (ctrl_i.op)
        gda_pkg::OP_ACCEPT: begin
          ovf_q <= 1'b0;
          unique case (cmd_i)
            gda_pkg::CMD_LOAD: begin
              year_q  <= YB'(load_year_i);
              month_q <= load_month;
              day_q   <= load_day;
            end
            gda_pkg::CMD_YEARS: begin
              year_q <= ysum_amt[YB-1:0];
              ovf_q  <= |ysum_amt[SW-1:YB];
            end
            default: begin
            end
          endcase
        end
        gda_pkg::OP_CYC: begin
          year_q <= year_q + YB'(gda_pkg::YEARS_400);
        end
        gda_pkg::OP_WALK: begin
          if (stat_o.walk_done) begin
            day_q <= acc_q[gda_pkg::DAY_W-1:0];
          end else if (stat_o.walk_wrap) begin
            month_q <= gda_pkg::MONTH_JAN;
            year_q  <= year_q + YB'(1);
            if (year_q == YB'(gda_pkg::YEAR_MAX)) begin
              ovf_q <= 1'b1;
            end
          end else begin
            month_q <= month_q + gda_pkg::MONTH_W'(1);
          end
        end
        gda_pkg::OP_MR: begin
          month_q <= rem12[gda_pkg::MONTH_W-1:0] + gda_pkg::MONTH_JAN;
          year_q  <= ysum_q12[YB-1:0];
          ovf_q   <= |ysum_q12[SW-1:YB];
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      gda_pkg::OP_ACCEPT: begin
        if (cmd_i == gda_pkg::CMD_DAYS) begin
          acc_q <= AW'(day_q) + AW'(amt);
        end else begin
          acc_q <= AW'(month_q - gda_pkg::MONTH_JAN) + AW'(amt);
        end
      end
      gda_pkg::OP_CYC:  acc_q  <= acc_q - AW'(gda_pkg::DAYS_400);
      gda_pkg::OP_LQ:   q100_q <= prod100[gda_pkg::P100_W-1:gda_pkg::SHIFT_100];
      gda_pkg::OP_LF:   leap_q <= leap;
      gda_pkg::OP_WALK: begin
        if (!stat_o.walk_done) begin
          acc_q <= acc_q - AW'(len);
        end
      end
      gda_pkg::OP_MQ:   q12_q  <= prod12[gda_pkg::P12_W-1:gda_pkg::SHIFT_12];
      default: begin
      end
    endcase
  end

  assign out_year_o      = gda_pkg::YEAR_W'(year_q);
  assign out_month_o     = month_q;
  assign out_day_o       = day_q;
  assign year_overflow_o = ovf_q;

  `GDA_ASSERT(a_month_range, (month_q != '0) && (month_q <= gda_pkg::MONTH_DEC), "month out of range")
  `GDA_ASSERT(a_day_nonzero, day_q != '0, "stored day is zero")
  `GDA_ASSERT_NEXT(a_walk_shrinks, (ctrl_i.op == gda_pkg::OP_WALK) && !stat_o.walk_done, acc_q < $past(acc_q), "day walk did not consume days")

endmodule

// ===== rtl/gda_ctrl.sv =====
// Sequencer for load, day walk, month and year commands.
`include "gregorian_date_adder_macros.svh"

module gda_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [gda_pkg::CMD_W-1:0]  in_cmd_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  gda_pkg::dp_stat_t          stat_i,
  output gda_pkg::dp_cmd_t           ctrl_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CYC  = 3'd1;
  localparam logic [2:0] ST_LQ   = 3'd2;
  localparam logic [2:0] ST_LF   = 3'd3;
  localparam logic [2:0] ST_WALK = 3'd4;
  localparam logic [2:0] ST_MQ   = 3'd5;
  localparam logic [2:0] ST_MR   = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d   = state_q;
    ctrl_o.op = gda_pkg::OP_IDLE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.op = gda_pkg::OP_ACCEPT;
          unique case (in_cmd_i)
            gda_pkg::CMD_DAYS:   state_d = ST_CYC;
            gda_pkg::CMD_MONTHS: state_d = ST_MQ;
            default:             state_d = ST_DONE;
          endcase
        end
      end
      ST_CYC: begin
        // whole 400-year cycles first, then the month walk
        if (stat_i.cyc_go) begin
          ctrl_o.op = gda_pkg::OP_CYC;
        end else begin
          state_d = ST_LQ;
        end
      end
      ST_LQ: begin
        ctrl_o.op = gda_pkg::OP_LQ;
        state_d   = ST_LF;
      end
      ST_LF: begin
        ctrl_o.op = gda_pkg::OP_LF;
        state_d   = ST_WALK;
      end
      ST_WALK: begin
        ctrl_o.op = gda_pkg::OP_WALK;
        if (stat_i.walk_done) begin
          state_d = ST_DONE;
        end else if (stat_i.walk_wrap) begin
          state_d = ST_LQ;  // new year: leap flag is stale
        end
      end
      ST_MQ: begin
        ctrl_o.op = gda_pkg::OP_MQ;
        state_d   = ST_MR;
      end
      ST_MR: begin
        ctrl_o.op = gda_pkg::OP_MR;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);

  `GDA_ASSERT(a_one_word_in_flight, !(in_ready_o && out_valid_o), "input taken while result pending")
  `GDA_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != ST_IDLE, "accepted word dropped")
  `GDA_ASSERT_NEXT(a_walk_ends_done, (state_q == ST_WALK) && stat_i.walk_done, state_q == ST_DONE, "finished walk did not report")
  `GDA_ASSERT_IMP(a_walk_op, state_q == ST_WALK, ctrl_o.op == gda_pkg::OP_WALK, "walk state without walk step")

endmodule

// ===== rtl/gregorian_date_adder.sv =====
// Top level of the Gregorian date adder.
//
//   port    dir   word                                          handshake
//   in_i    in    cmd, load_year, load_month, load_day, amount  valid/ready
//   out_o   out   out_year, out_month, out_day, year_overflow   valid/ready
//
// One word at a time: a word is taken in idle, its result is offered until taken.
// Load and add-years finish in the accept step. Add-months: multiply step (MQ), then remainder step (MR).
// Add-days: 400-year steps, then the month walk, one month per cycle, with a fresh leap
// flag (LQ, LF) before it and per year crossed; the largest amount walks ~2150 months.
// Reset gives year 0, January 1; overflow flag clear.
// A stalled result holds the block in its done state; nothing else waits.
module gregorian_date_adder (
  input  logic      clk_i,
  input  logic      rst_ni,
  gda_in_if.sink    in_i,
  gda_out_if.source out_o
);

  gda_pkg::dp_cmd_t  ctrl;
  gda_pkg::dp_stat_t stat;

  gda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  gda_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cmd_i           (in_i.cmd),
    .load_year_i     (in_i.load_year),
    .load_month_i    (in_i.load_month),
    .load_day_i      (in_i.load_day),
    .amount_i        (in_i.amount),
    .out_year_o      (out_o.out_year),
    .out_month_o     (out_o.out_month),
    .out_day_o       (out_o.out_day),
    .year_overflow_o (out_o.year_overflow)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the Gregorian date adder: directed and random command words.
module testbench;

  typedef struct packed {
    logic [gda_pkg::CMD_W-1:0]    cmd;
    logic [gda_pkg::YEAR_W-1:0]   load_year;
    logic [gda_pkg::MONTH_W-1:0]  load_month;
    logic [gda_pkg::DAY_W-1:0]    load_day;
    logic [gda_pkg::AMOUNT_W-1:0] amount;
  } date_cmd_t;

  typedef struct packed {
    logic [gda_pkg::YEAR_W-1:0]  year;
    logic [gda_pkg::MONTH_W-1:0] month;
    logic [gda_pkg::DAY_W-1:0]   day;
    logic                        ovf;
  } date_res_t;

  logic clk_i;
  logic rst_ni;

  gda_in_if  in_if ();
  gda_out_if out_if ();

  gregorian_date_adder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  date_cmd_t cmds_to_send[$];
  date_res_t dates_due[$];

  // calendar state as the block should hold it
  longint unsigned cal_year;
  int unsigned     cal_month;
  int unsigned     cal_day;

  int tx_idle_pct;
  int rx_idle_pct;
  int phase;
  logic rx_hold;
  logic in_fire;
  int unsigned n_fail;
  int unsigned n_checked;
  int unsigned n_by_cmd[4];
  int unsigned n_wraps;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic bit leap_year(longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(longint unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      2: len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  // adds n years, wraps, returns 1 on wrap
  function automatic bit bump_year(longint unsigned n);
    longint unsigned sum;
    sum = cal_year + n;
    cal_year = sum & gda_pkg::YEAR_MAX;
    return (sum >> gda_pkg::YEAR_BITS) != 0;
  endfunction

  function automatic void advance_date(date_cmd_t w);
    longint unsigned s;
    longint unsigned t;
    bit ovf;
    date_res_t r;
    ovf = 1'b0;
    case (w.cmd)
      gda_pkg::CMD_LOAD: begin
        cal_year = 64'(w.load_year);
        if (w.load_month == '0) cal_month = 1;
        else if (w.load_month > gda_pkg::MONTH_DEC) cal_month = 12;
        else cal_month = 32'(w.load_month);
        cal_day = (w.load_day == '0) ? 1 : 32'(w.load_day);
      end
      gda_pkg::CMD_DAYS: begin
        s = 64'(cal_day) + 64'(w.amount);
        while (s > gda_pkg::DAYS_400 && cal_year + gda_pkg::YEARS_400 <= gda_pkg::YEAR_MAX) begin
          s -= gda_pkg::DAYS_400;
          cal_year += gda_pkg::YEARS_400;
        end
        // a day beyond the month end spills forward too
        while (s > 64'(month_days(cal_year, cal_month))) begin
          s -= 64'(month_days(cal_year, cal_month));
          cal_month++;
          if (cal_month > 12) begin
            cal_month = 1;
            if (bump_year(64'd1)) ovf = 1'b1;
          end
        end
        cal_day = 32'(s);
      end
      gda_pkg::CMD_MONTHS: begin
        t = 64'(cal_month - 1) + 64'(w.amount);
        ovf = bump_year(t / 12);
        cal_month = 32'(t % 12) + 1;
      end
      default: ovf = bump_year(64'(w.amount));
    endcase
    r.year = cal_year[gda_pkg::YEAR_W-1:0];
    r.month = cal_month[gda_pkg::MONTH_W-1:0];
    r.day = cal_day[gda_pkg::DAY_W-1:0];
    r.ovf = ovf;
    n_by_cmd[w.cmd]++;
    if (ovf) n_wraps++;
    dates_due.push_back(r);
  endfunction

  function automatic date_cmd_t mk_load(int unsigned y, int unsigned m, int unsigned d);
    date_cmd_t w;
    w.cmd = gda_pkg::CMD_LOAD;
    w.load_year = y[gda_pkg::YEAR_W-1:0];
    w.load_month = m[gda_pkg::MONTH_W-1:0];
    w.load_day = d[gda_pkg::DAY_W-1:0];
    w.amount = '0;
    return w;
  endfunction

  function automatic date_cmd_t mk_step(logic [gda_pkg::CMD_W-1:0] c, int unsigned a);
    date_cmd_t w;
    w = '0;
    w.cmd = c;
    w.amount = a[gda_pkg::AMOUNT_W-1:0];
    return w;
  endfunction

  function automatic date_cmd_t random_cmd();
    date_cmd_t w;
    int pick;
    int sz;
    pick = int'($urandom_range(99));
    sz = int'($urandom_range(99));
    // unused fields carry noise
    w.load_year = 16'($urandom_range(65535));
    w.load_month = 4'($urandom_range(15));
    w.load_day = 5'($urandom_range(31));
    w.amount = 16'($urandom_range(65535));
    if (pick < 20) begin
      w.cmd = gda_pkg::CMD_LOAD;
      if (sz < 10) w.load_year = 16'(65535 - $urandom_range(3));
      if ($urandom_range(9) != 0) w.load_month = 4'($urandom_range(12, 1));
      if ($urandom_range(99) < 85) w.load_day = 5'($urandom_range(28, 1));
    end else if (pick < 60) begin
      w.cmd = gda_pkg::CMD_DAYS;
      // long day walks are slow, keep most of them short
      if (sz < 70) w.amount = 16'($urandom_range(400));
      else if (sz < 92) w.amount = 16'($urandom_range(4000));
    end else if (pick < 80) begin
      w.cmd = gda_pkg::CMD_MONTHS;
      if (sz < 50) w.amount = 16'($urandom_range(30));
    end else begin
      w.cmd = gda_pkg::CMD_YEARS;
      if (sz < 60) w.amount = 16'($urandom_range(100));
    end
    return w;
  endfunction

  task automatic report(string what, longint unsigned want, longint unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    n_fail++;
  endtask

  // driver: new word at the falling edge once the previous one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_fire)) begin
      if (cmds_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        date_cmd_t w;
        w = cmds_to_send.pop_front();
        in_if.cmd <= w.cmd;
        in_if.load_year <= w.load_year;
        in_if.load_month <= w.load_month;
        in_if.load_day <= w.load_day;
        in_if.amount <= w.amount;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready)
      advance_date({in_if.cmd, in_if.load_year, in_if.load_month, in_if.load_day,
                    in_if.amount});
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // monitor: compare each taken result with the oldest prediction
  always @(posedge clk_i) begin : take_result
    date_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_checked++;
      if (dates_due.size() == 0) begin
        $display("%0t: result with nothing expected, actual %0d-%0d-%0d ovf %0b", $time,
                 out_if.out_year, out_if.out_month, out_if.out_day, out_if.year_overflow);
        n_fail++;
      end else begin
        want = dates_due.pop_front();
        if (out_if.out_year !== want.year) report("year", want.year, out_if.out_year);
        if (out_if.out_month !== want.month) report("month", want.month, out_if.out_month);
        if (out_if.out_day !== want.day) report("day", want.day, out_if.out_day);
        if (out_if.year_overflow !== want.ovf)
          report("overflow", want.ovf, out_if.year_overflow);
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    rx_hold = 1'b0;
    wait (phase == 3);
    repeat (4) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  task automatic wait_sent();
    wait (cmds_to_send.size() == 0 && !in_if.valid);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = gda_pkg::CMD_LOAD;
    in_if.load_year = '0;
    in_if.load_month = '0;
    in_if.load_day = '0;
    in_if.amount = '0;
    out_if.ready = 1'b0;
    in_fire = 1'b0;
    cal_year = 0;
    cal_month = 1;
    cal_day = 1;
    n_fail = 0;
    n_checked = 0;
    n_wraps = 0;
    n_by_cmd = '{default: 0};
    phase = 1;
    tx_idle_pct = 22;
    rx_idle_pct = 80;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cmds_to_send.push_back(mk_step(gda_pkg::CMD_DAYS, 0));       // reset date as is
    cmds_to_send.push_back(mk_load(2023, 2, 31));                // Feb 31 spills, common year
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_DAYS, 0));
    cmds_to_send.push_back(mk_load(2024, 2, 31));                // same, leap year
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_DAYS, 0));
    cmds_to_send.push_back(mk_load(1900, 2, 28));                // century, not leap
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_DAYS, 1));
    cmds_to_send.push_back(mk_load(2000, 2, 28));                // 400-year rule, leap
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_DAYS, 1));
    cmds_to_send.push_back(mk_load(0, 0, 0));                    // month and day zero
    cmds_to_send.push_back(mk_load(65535, 15, 31));              // month above 12
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_DAYS, 1));       // wrap by a day
    cmds_to_send.push_back(mk_load(65535, 13, 30));
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_YEARS, 1));
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_YEARS, 65535));
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_MONTHS, 65535));
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_MONTHS, 0));
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_YEARS, 0));
    cmds_to_send.push_back(mk_load(1999, 12, 31));
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_DAYS, 65535));
    cmds_to_send.push_back(mk_load(16'hAAAA, 14, 21));
    cmds_to_send.push_back(mk_load(16'h5555, 5, 10));
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_DAYS, 16'hAAAA));
    cmds_to_send.push_back(mk_step(gda_pkg::CMD_MONTHS, 16'h5555));
    // sender stops until everything is back
    wait_sent();
    wait (dates_due.size() == 0);

    repeat (82) cmds_to_send.push_back(random_cmd());
    wait_sent();
    phase = 2;
    tx_idle_pct = 80;
    rx_idle_pct = 22;
    repeat (82) cmds_to_send.push_back(random_cmd());
    wait_sent();
    phase = 3;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (82) cmds_to_send.push_back(random_cmd());
    wait_sent();
    wait (dates_due.size() == 0);
    repeat (30) @(posedge clk_i);

    $display("Checked %0d results: %0d loads, %0d day, %0d month, %0d year additions,",
             n_checked, n_by_cmd[gda_pkg::CMD_LOAD], n_by_cmd[gda_pkg::CMD_DAYS],
             n_by_cmd[gda_pkg::CMD_MONTHS], n_by_cmd[gda_pkg::CMD_YEARS]);
    $display("%0d year wraps, three idle mixes and a long output stall.", n_wraps);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding", dates_due.size());
    $display("FAILURE");
    $finish;
  end

endmodule
